// ===== hdl/trb_pkg.sv =====
package trb_pkg;

  // Search and table sizing
  localparam int MAX_STEPS     = 32;
  localparam int LN_TABLE_BITS = 10;
  localparam int LN_TABLE_SIZE = 1 << LN_TABLE_BITS;
  localparam int LN_W          = 26;                 // Q26 table entry width
  localparam int DIV_W         = LN_TABLE_BITS + 32; // dividend width
  localparam int DVS_W         = LN_TABLE_BITS + 2;  // divisor width
  localparam int EVAL_LAT      = 7;                  // r load to sign ready

  // Fixed Steinhart-Hart coefficients
  localparam logic [32:0] SH_A40 = 33'd1241568530;
  localparam logic [34:0] SH_B56 = 35'd16868682764;
  localparam logic [32:0] SH_C56 = 33'd6323342107;
  localparam logic signed [15:0] KELVIN_OFFSET16 = 16'sd4370;

  // Configuration register indexes
  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_TOL  = 2'd2;

  typedef enum logic [2:0] {
    C_IDLE, C_CHECK, C_EVAL_LO, C_EVAL_Y, C_DECIDE, C_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    B_JOB, B_DIVZ, B_Z2, B_TERM, B_DIVT, B_ACC, B_STORE, B_READY
  } build_state_e;

  typedef struct packed {
    logic start;
    logic load_r;
    logic r_sel_y;
    logic cap_lo;
    logic cap_y;
    logic step_inc;
    logic decide;
    logic out_load;
    logic out_status;
  } trb_cmd_t;

  typedef struct packed {
    logic within_tol;
    logic at_cap;
    logic signs_differ;
  } trb_stat_t;

endpackage

// ===== hdl/trb_lntab.sv =====
module trb_lntab (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [trb_pkg::LN_TABLE_BITS-1:0]   rd_addr_i,
  output logic [trb_pkg::LN_W-1:0]            rd_data_o,
  output logic [trb_pkg::LN_W-1:0]            ln2_o,
  output logic                                ready_o
);
  import trb_pkg::*;

  localparam int JOB_W = LN_TABLE_BITS + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  build_state_e state_q, state_d;
  logic [JOB_W-1:0]  job_q, job_d;
  logic [6:0]        k_q, k_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [31:0]       z2_q, z2_d, t_q, t_d;
  logic [33:0]       sum_q, sum_d;
  logic [LN_W-1:0]   ln2_q, ln2_d;
  logic              wr_en;
  logic [LN_W-1:0]   wr_val;

  logic [LN_W-1:0] mem_q [LN_TABLE_SIZE];
  logic [LN_W-1:0] rd_q;

  logic [DVS_W:0] rem_sh;
  logic           q_bit;
  logic [63:0]    zz, tz;
  logic [35:0]    rnd;
  logic           last_job;

  // One restoring divide step
  assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
  assign q_bit  = rem_sh >= {1'b0, dvs_q};
  assign zz     = 64'(dvd_q[31:0]) * 64'(dvd_q[31:0]);
  assign tz     = 64'(t_q) * 64'(z2_q);
  assign rnd    = {1'b0, sum_q, 1'b0} + 36'd32;
  assign last_job = job_q == JOB_W'(LN_TABLE_SIZE);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    k_d     = k_q;
    dcnt_d  = dcnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    z2_d    = z2_q;
    t_d     = t_q;
    sum_d   = sum_q;
    ln2_d   = ln2_q;
    wr_en   = 1'b0;
    wr_val  = rnd[31:6];
    case (state_q)
      B_JOB: begin
        // z = num / den in Q32; last job is ln 2 from 1/3
        if (last_job) begin
          dvd_d = DIV_W'(64'd1 << 32);
          dvs_d = DVS_W'(3);
        end else begin
          dvd_d = {job_q[LN_TABLE_BITS-1:0], 32'd0};
          dvs_d = {2'b10, job_q[LN_TABLE_BITS-1:0]};
        end
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = B_DIVZ;
      end
      B_DIVZ, B_DIVT: begin
        dvd_d  = {dvd_q[DIV_W-2:0], q_bit};
        rem_d  = q_bit ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(DIV_W - 1)) begin
          state_d = (state_q == B_DIVZ) ? B_Z2 : B_ACC;
        end
      end
      B_Z2: begin
        // Square the fresh quotient and start the series at z
        z2_d    = zz[63:32];
        t_d     = dvd_q[31:0];
        sum_d   = '0;
        k_d     = '0;
        state_d = B_TERM;
      end
      B_TERM: begin
        if (t_q == '0 || k_q == 7'd64) begin
          state_d = B_STORE;
        end else begin
          dvd_d   = DIV_W'(t_q);
          dvs_d   = DVS_W'({k_q, 1'b1});
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = B_DIVT;
        end
      end
      B_ACC: begin
        sum_d   = sum_q + 34'(dvd_q[31:0]);
        t_d     = tz[63:32];
        k_d     = k_q + 1'b1;
        state_d = B_TERM;
      end
      B_STORE: begin
        if (last_job) begin
          ln2_d   = rnd[31:6];
          state_d = B_READY;
        end else begin
          wr_en   = 1'b1;
          job_d   = job_q + 1'b1;
          state_d = B_JOB;
        end
      end
      B_READY: begin
        state_d = B_READY;
      end
      default: begin
        state_d = B_JOB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_JOB;
      job_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    dcnt_q <= dcnt_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    z2_q   <= z2_d;
    t_q    <= t_d;
    sum_q  <= sum_d;
    ln2_q  <= ln2_d;
  end

  // Table memory: written by the builder, read every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[job_q[LN_TABLE_BITS-1:0]] <= wr_val;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;
  assign ln2_o     = ln2_q;
  assign ready_o   = state_q == B_READY;

endmodule

// ===== hdl/trb_datapath.sv =====
module trb_datapath (
  input  logic                                clk_i,
  input  trb_pkg::trb_cmd_t                   cmd_i,
  output trb_pkg::trb_stat_t                  stat_o,
  input  logic [23:0]                         cfg_low_i,
  input  logic [23:0]                         cfg_high_i,
  input  logic [23:0]                         cfg_tol_i,
  input  logic signed [14:0]                  target_temp_i,
  output logic [trb_pkg::LN_TABLE_BITS-1:0]   tab_addr_o,
  input  logic [trb_pkg::LN_W-1:0]            tab_data_i,
  input  logic [trb_pkg::LN_W-1:0]            ln2_i,
  output logic [23:0]                         resistance_ohms_o,
  output logic [6:0]                          step_count_o,
  output logic                                status_o
);
  import trb_pkg::*;

  localparam logic signed [49:0] F_ONE = 50'sd1 <<< 44;

  logic [23:0] lo_q, hi_q, tol_q, r_q;
  logic signed [15:0] kel_q;
  logic [6:0]  steps_q;
  logic [1:0]  sign_q, sign_lo_q, sign_y_q;  // {negative, zero}
  logic [23:0] y_w, diff_w, r_eff;
  logic [24:0] sum_w;
  logic [4:0]  p_w, p_q;
  logic [23:0] norm_w;
  logic [30:0] ln_w;
  logic [20:0] l16_q;
  logic [25:0] l2_q;
  logic [30:0] l3_q;
  logic [23:0] tb_q;
  logic [31:0] tc_q;
  logic [41:0] sq_w;
  logic [46:0] cu_w;
  logic [55:0] pb_w;
  logic [63:0] pc_w;
  logic [32:0] sh_w;
  logic signed [49:0] prod_w, prod_q;

  // Midpoint and distance from the low bound
  assign sum_w  = {1'b0, lo_q} + {1'b0, hi_q};
  assign y_w    = sum_w[24:1];
  assign diff_w = (lo_q > y_w) ? (lo_q - y_w) : (y_w - lo_q);

  assign stat_o.within_tol   = diff_w <= tol_q;
  assign stat_o.at_cap       = steps_q >= 7'(MAX_STEPS);
  assign stat_o.signs_differ = sign_lo_q[0] | sign_y_q[0] | (sign_lo_q[1] ^ sign_y_q[1]);

  // Search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      lo_q    <= cfg_low_i;
      hi_q    <= cfg_high_i;
      tol_q   <= cfg_tol_i;
      kel_q   <= 16'(target_temp_i) + KELVIN_OFFSET16;
      steps_q <= '0;
    end else begin
      if (cmd_i.step_inc) begin
        steps_q <= steps_q + 1'b1;
      end
      if (cmd_i.decide) begin
        if (stat_o.signs_differ) begin
          hi_q <= y_w;
        end else begin
          lo_q      <= y_w;
          sign_lo_q <= sign_y_q;
        end
      end
    end
    if (cmd_i.load_r) begin
      r_q <= cmd_i.r_sel_y ? y_w : lo_q;
    end
    if (cmd_i.cap_lo) begin
      sign_lo_q <= sign_q;
    end
    if (cmd_i.cap_y) begin
      sign_y_q <= sign_q;
    end
    if (cmd_i.out_load) begin
      resistance_ohms_o <= y_w;
      step_count_o      <= steps_q;
      status_o          <= cmd_i.out_status;
    end
  end

  // Leading-one position; zero evaluates as one ohm
  assign r_eff = (r_q == '0) ? 24'd1 : r_q;
  always_comb begin
    p_w = '0;
    for (int i = 0; i < 24; i++) begin
      if (r_eff[i]) begin
        p_w = 5'(i);
      end
    end
  end
  assign norm_w     = r_eff << (5'd23 - p_w);
  assign tab_addr_o = norm_w[22 -: LN_TABLE_BITS];

  // Evaluation pipeline: ln, square, cube, products, sign
  assign ln_w = 31'(p_q) * 31'(ln2_i) + 31'(tab_data_i);
  assign sq_w = 42'(l16_q) * 42'(l16_q);
  assign cu_w = 47'(l2_q) * 47'(l16_q);
  assign pb_w = 56'(SH_B56) * 56'(l16_q);
  assign pc_w = 64'(SH_C56) * 64'(l3_q);
  assign sh_w = SH_A40 + 33'(tb_q) + 33'(tc_q);
  assign prod_w = 50'(signed'({1'b0, sh_w})) * 50'(kel_q);

  always_ff @(posedge clk_i) begin
    p_q    <= p_w;
    l16_q  <= ln_w[30:10];
    l2_q   <= sq_w[41:16];
    l3_q   <= cu_w[46:16];
    tb_q   <= pb_w[55:32];
    tc_q   <= pc_w[63:32];
    prod_q <= prod_w;
    sign_q <= {prod_q < F_ONE, prod_q == F_ONE};
  end

endmodule

// ===== hdl/trb_ctrl.sv =====
module trb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 tab_ready_i,
  input  logic                 out_stall_i,
  input  trb_pkg::trb_stat_t   stat_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output trb_pkg::trb_cmd_t    cmd_o
);
  import trb_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        lo_known_q, lo_known_d;
  logic        cap_q, cap_d;
  logic        ov_q, ov_d;
  logic        out_free;

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = !(state_q == C_IDLE && tab_ready_i);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q + 1'b1;
    lo_known_d = lo_known_q;
    cap_d      = cap_q;
    ov_d       = ov_q && out_stall_i;
    cmd_o      = '0;
    cmd_o.out_status = cap_q;
    case (state_q)
      C_IDLE: begin
        if (in_valid_i && tab_ready_i) begin
          cmd_o.start = 1'b1;
          lo_known_d  = 1'b0;
          state_d     = C_CHECK;
        end
      end
      C_CHECK: begin
        // Stop on tolerance, then on the step cap, else take a step
        if (stat_i.within_tol) begin
          cap_d   = 1'b0;
          state_d = C_DONE;
        end else if (stat_i.at_cap) begin
          cap_d   = 1'b1;
          state_d = C_DONE;
        end else begin
          cmd_o.step_inc = 1'b1;
          cmd_o.load_r   = 1'b1;
          cmd_o.r_sel_y  = lo_known_q;
          cnt_d          = '0;
          state_d        = lo_known_q ? C_EVAL_Y : C_EVAL_LO;
        end
      end
      C_EVAL_LO: begin
        if (cnt_q == 3'(EVAL_LAT)) begin
          cmd_o.cap_lo  = 1'b1;
          cmd_o.load_r  = 1'b1;
          cmd_o.r_sel_y = 1'b1;
          lo_known_d    = 1'b1;
          cnt_d         = '0;
          state_d       = C_EVAL_Y;
        end
      end
      C_EVAL_Y: begin
        if (cnt_q == 3'(EVAL_LAT)) begin
          cmd_o.cap_y = 1'b1;
          state_d     = C_DECIDE;
        end
      end
      C_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = C_CHECK;
      end
      C_DONE: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ov_d           = 1'b1;
          state_d        = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= C_IDLE;
      cnt_q      <= '0;
      lo_known_q <= 1'b0;
      cap_q      <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      lo_known_q <= lo_known_d;
      cap_q      <= cap_d;
      ov_q       <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

// ===== hdl/thermistor_resistance_bisection.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   target_temp_i
// result    out        out_valid_o / out_stall_i resistance_ohms_o, step_count_o, status_o
// config    in         APB psel/penable/pwrite   paddr_i, pwdata_i, prdata_o
//
// Each halving step loads r, evaluates it (the low bound only on the first step of an item)
// and then decides; the seven-stage evaluation pipeline sets the step.
// After reset a serial divider builds the ln table, 1024 entries and then ln 2;
// no item is taken until then.
// A result waits in the output register while the next item is taken and searched.
module thermistor_resistance_bisection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [14:0] target_temp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [23:0]        resistance_ohms_o,
  output logic [6:0]         step_count_o,
  output logic               status_o
);
  import trb_pkg::*;

  logic [23:0] low_q, high_q, tol_q;
  logic        wr_en;
  trb_cmd_t    cmd;
  trb_stat_t   stat;
  logic [LN_TABLE_BITS-1:0] tab_addr;
  logic [LN_W-1:0] tab_data, ln2;
  logic        tab_ready;

  // Register writes
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= 24'd1000;
      high_q <= 24'd100000;
      tol_q  <= 24'd1;
    end else if (wr_en) begin
      case (paddr_i[3:2])
        REG_LOW:  low_q  <= pwdata_i[23:0];
        REG_HIGH: high_q <= pwdata_i[23:0];
        REG_TOL:  tol_q  <= pwdata_i[23:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr_i[3:2])
      REG_LOW:  prdata_o = {8'd0, low_q};
      REG_HIGH: prdata_o = {8'd0, high_q};
      REG_TOL:  prdata_o = {8'd0, tol_q};
      default:  prdata_o = '0;
    endcase
  end

  trb_lntab u_lntab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (tab_addr),
    .rd_data_o (tab_data),
    .ln2_o     (ln2),
    .ready_o   (tab_ready)
  );

  trb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .tab_ready_i (tab_ready),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  trb_datapath u_datapath (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_low_i         (low_q),
    .cfg_high_i        (high_q),
    .cfg_tol_i         (tol_q),
    .target_temp_i     (target_temp_i),
    .tab_addr_o        (tab_addr),
    .tab_data_i        (tab_data),
    .ln2_i             (ln2),
    .resistance_ohms_o (resistance_ohms_o),
    .step_count_o      (step_count_o),
    .status_o          (status_o)
  );

endmodule

// ===== tb/thermistor_resistance_bisection_checker.sv =====
module thermistor_resistance_bisection_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [14:0] target_temp_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [23:0]        resistance_ohms_i,
  input  logic [6:0]         step_count_i,
  input  logic               status_i,
  output int                 err_count_o,
  output int                 pending_o
);
  import trb_pkg::*;

  typedef struct packed {
    logic [23:0] ohms;
    logic [6:0]  steps;
    logic        capped;
  } root_t;

  localparam longint signed SH_A = 64'sd1241568530;
  localparam longint unsigned SH_B = 64'd16868682764;
  localparam longint unsigned SH_C = 64'd6323342107;

  logic [31:0] ln_mant[LN_TABLE_SIZE];
  logic [31:0] ln2_q;
  logic [23:0] bound_lo, bound_hi, tol;
  root_t       roots_due[$];

  // 2*atanh(num/den) by series, rounded to Q26
  function automatic logic [31:0] atanh2(longint unsigned num, longint unsigned den);
    longint unsigned z, z2, t, acc;
    z   = (num << 32) / den;
    z2  = (z * z) >> 32;
    t   = z;
    acc = 0;
    for (int k = 0; k < 64 && t != 0; k++) begin
      acc += t / longint'(2 * k + 1);
      t = (t * z2) >> 32;
    end
    return 32'((2 * acc + 32) >> 6);
  endfunction

  function automatic logic [31:0] ln_fixed(logic [31:0] r);
    int unsigned p;
    logic [31:0] frac, idx;
    if (r == 0) r = 1;
    p = 0;
    while (p < 31 && (r >> (p + 1)) != 0) p++;
    frac = r - (32'd1 << p);
    if (p >= LN_TABLE_BITS) idx = frac >> (p - LN_TABLE_BITS);
    else idx = frac << (LN_TABLE_BITS - p);
    idx &= LN_TABLE_SIZE - 1;
    return p * ln2_q + ln_mant[idx];
  endfunction

  // sign of SH(ln r) * kelvin - 1
  function automatic int curve_sign(logic [31:0] r, longint signed kel);
    longint unsigned l16, l2, l3;
    longint signed sh, f;
    l16 = longint'(ln_fixed(r) >> 10);
    l2  = (l16 * l16) >> 16;
    l3  = (l2 * l16) >> 16;
    sh  = SH_A + longint'((SH_B * l16) >> 32) + longint'((SH_C * l3) >> 32);
    f   = sh * kel - (64'sd1 <<< 44);
    return (f > 0) ? 1 : ((f < 0) ? -1 : 0);
  endfunction

  function automatic root_t bisect_root(logic signed [14:0] temp);
    longint signed kel;
    logic [31:0] lo, hi, y, diff;
    root_t res;
    kel = longint'(temp) + 4370;
    lo = bound_lo;
    hi = bound_hi;
    res = '0;
    forever begin
      y = 32'((longint'(lo) + longint'(hi)) >> 1);
      diff = (lo > y) ? lo - y : y - lo;
      if (diff <= tol) break;
      if (res.steps >= MAX_STEPS) begin
        res.capped = 1'b1;
        break;
      end
      res.steps++;
      if (curve_sign(lo, kel) * curve_sign(y, kel) <= 0) hi = y;
      else lo = y;
    end
    res.ohms = y[23:0];
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_count_o++;
  endtask

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    for (int i = 0; i < LN_TABLE_SIZE; i++)
      ln_mant[i] = atanh2(i, 2 * LN_TABLE_SIZE + i);
    ln2_q = atanh2(1, 3);
  end

  // track register writes, queue expected roots, compare result beats
  always @(posedge clk_i or negedge rst_ni) begin : watch
    root_t want;
    if (!rst_ni) begin
      bound_lo <= 24'd1000;
      bound_hi <= 24'd100000;
      tol      <= 24'd1;
      roots_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_LOW:  bound_lo <= pwdata_i[23:0];
          REG_HIGH: bound_hi <= pwdata_i[23:0];
          REG_TOL:  tol      <= pwdata_i[23:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) roots_due.push_back(bisect_root(target_temp_i));
      if (out_valid_i && !out_stall_i) begin
        if (roots_due.size() == 0) begin
          report("unexpected result beat", 32'(resistance_ohms_i), 32'd0);
        end else begin
          want = roots_due.pop_front();
          if (resistance_ohms_i !== want.ohms)
            report("resistance", 32'(resistance_ohms_i), 32'(want.ohms));
          if (step_count_i !== want.steps)
            report("steps", 32'(step_count_i), 32'(want.steps));
          if (status_i !== want.capped)
            report("status", 32'(status_i), 32'(want.capped));
        end
      end
    end
    pending_o = roots_due.size();
  end

endmodule

// ===== tb/thermistor_resistance_bisection_tb.sv =====
module thermistor_resistance_bisection_tb;
  import trb_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam logic signed [14:0] CORNERS [6] = '{-15'sd16384, 15'sd16383, -15'sd4370,
                                                  -15'sd4368, 15'sd16000, 15'sd0};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel_i = 1'b0;
  logic               penable_i = 1'b0;
  logic               pwrite_i = 1'b0;
  logic [3:0]         paddr_i = '0;
  logic [31:0]        pwdata_i = '0;
  logic [31:0]        prdata_o;
  logic               pready_o;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [14:0] target_temp_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [23:0]        resistance_ohms_o;
  logic [6:0]         step_count_o;
  logic               status_o;
  int                 err_count, pending;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  int                 cycles = 0;

  thermistor_resistance_bisection u_top (.*);

  thermistor_resistance_bisection_checker u_chk (
    .clk_i, .rst_ni, .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i,
    .pready_i(pready_o), .in_valid_i, .in_stall_i(in_stall_o), .target_temp_i,
    .out_valid_i(out_valid_o), .out_stall_i, .resistance_ohms_i(resistance_ohms_o),
    .step_count_i(step_count_o), .status_i(status_o),
    .err_count_o(err_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // stall the result channel at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("thermistor_resistance_bisection_tb: done, errors");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [23:0] val);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {idx, 2'b00};
    pwdata_i  <= {8'($urandom), val};
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  task automatic set_search(logic [23:0] lo, logic [23:0] hi, logic [23:0] t);
    reg_write(REG_LOW, lo);
    reg_write(REG_HIGH, hi);
    reg_write(REG_TOL, t);
  endtask

  // hold one temperature beat until taken
  task automatic send_temp(logic signed [14:0] temp);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    target_temp_i <= temp;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // let the last accepted beat reach the checker before polling
  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic signed [14:0] rand_temp();
    if ($urandom_range(9) == 0) return 15'($urandom);
    return 15'($urandom_range(20368) - 4368);
  endfunction

  function automatic logic [23:0] rand_bound();
    case ($urandom_range(7))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom);
      default: return 24'($urandom_range(200000, 50));
    endcase
  endfunction

  function automatic logic [23:0] rand_tol();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'($urandom);
      default: return 24'($urandom_range(64));
    endcase
  endfunction

  task automatic random_run(int count, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int half = 0; half < 2; half++) begin
      drain();
      set_search(rand_bound(), rand_bound(), rand_tol());
      for (int i = 0; i < count / 2; i++) send_temp(rand_temp());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset bounds, then corner temperatures
    foreach (CORNERS[i]) send_temp(CORNERS[i]);
    drain();
    // zero low bound, full-range high, zero tolerance
    set_search(24'd0, 24'hFFFFFF, 24'd0);
    foreach (CORNERS[i]) send_temp(CORNERS[i]);
    drain();
    // reversed bounds; write to unused index dropped
    set_search(24'd200000, 24'd500, 24'd2);
    reg_write(2'd3, 24'd7);
    for (int i = 0; i < 4; i++) send_temp(CORNERS[i]);
    drain();
    // huge tolerance, zero steps
    set_search(24'd1, 24'd1, 24'hFFFFFF);
    send_temp(15'sd400);
    send_temp(-15'sd1000);
    drain();
    set_search(24'hFFFFFF, 24'd0, 24'd0);
    send_temp(15'sd320);
    send_temp(15'sd8000);

    random_run(560, 11, 46);
    random_run(560, 46, 11);
    random_run(560, 0, 0);
    drain();

    if (err_count == 0 && pending == 0) begin
      $display("thermistor_resistance_bisection_tb: done, clean");
    end else begin
      $display("thermistor_resistance_bisection_tb: done, errors");
    end
    $finish;
  end

endmodule
